// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is held (active low reset).
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked assertion that is also checked through reset.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== src/pgm_pkg.sv =====
// Package for pixel_gradient_mag_angle: constants, item types, arctangent table.
// No dependencies.
package pgm_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int MAX_HEIGHT     = 2048;
    localparam int ROW_BITS       = 11;
    localparam int POS_BITS       = 11;
    localparam int CFG_BITS       = 12;
    localparam int CFG_IDX_BITS   = 4;
    localparam int CORDIC_STEPS   = 30;
    localparam int PRESCALE       = 20;
    localparam int QUEUE_DEPTH    = 4;
    localparam int MAG_BITS       = 17;
    localparam int OUT_ANGLE_BITS = 16;

    localparam logic [CFG_BITS-1:0] LINE_WIDTH_RST   = 12'd640;
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = 12'd480;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_WIDTH   = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 4'd1;

    // One interior pixel handed from the front to the back.
    typedef struct packed {
        logic signed [8:0]    ix;
        logic signed [8:0]    iy;
        logic [POS_BITS-1:0]  cx;
        logic [POS_BITS-1:0]  cy;
        logic                 eof;
    } t_grad_item;

    // atan(2^-i) where a full turn is 2^32.
    function automatic logic [31:0] atan_turn32(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/pgm_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/pgm_fifo.sv =====
// Short queue of gradient items between front and back.
// Depends on pgm_pkg.
module pgm_fifo import pgm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_grad_item i_item,
    output logic       o_full,
    input  logic       i_pop,
    output t_grad_item o_item,
    output logic       o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_grad_item      r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
endmodule

// ===== src/pgm_front.sv =====
// Front end: raster position, two line stores, 3x3 window, central differences.
// Depends on pgm_pkg, pgm_ram.
module pgm_front import pgm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_pixel,
    input  logic                i_sof,
    input  logic [CFG_BITS-1:0] i_line_width,
    input  logic [CFG_BITS-1:0] i_frame_height,
    input  logic                i_q_full,
    output logic                o_push,
    output t_grad_item          o_item
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > CFG_BITS) ? CW + 1 : CFG_BITS;

    typedef enum logic [1:0] {
        FS_IDLE = 2'b01,
        FS_UPD  = 2'b10
    } t_front_state;

    t_front_state      r_state, n_state;
    logic [CW-1:0]     r_col, r_c;
    logic [ROW_BITS-1:0] r_row, r_r;
    logic [7:0]        r_p;
    logic [7:0]        r_win [3][3];
    logic [7:0]        top, mid;
    logic [CW-1:0]     c_eff;
    logic [ROW_BITS-1:0] r_eff;
    logic [WW-1:0]     w_cl, lw_ext, c_next;
    logic [CFG_BITS-1:0] h_cl, r_next;
    logic              accept, interior;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == FS_IDLE) && !i_q_full;
    assign c_eff   = i_sof ? '0 : r_col;
    assign r_eff   = i_sof ? '0 : r_row;

    // Clamp registers to the supported frame size.
    always_comb begin
        lw_ext = WW'(i_line_width);
        if (lw_ext < WW'(3)) begin
            w_cl = WW'(3);
        end else if (lw_ext > WW'(MAX_WIDTH)) begin
            w_cl = WW'(MAX_WIDTH);
        end else begin
            w_cl = lw_ext;
        end
        if (i_frame_height < CFG_BITS'(3)) begin
            h_cl = CFG_BITS'(3);
        end else if (i_frame_height > CFG_BITS'(MAX_HEIGHT)) begin
            h_cl = CFG_BITS'(MAX_HEIGHT);
        end else begin
            h_cl = i_frame_height;
        end
        c_next = WW'(r_c) + WW'(1);
        r_next = CFG_BITS'(r_r) + CFG_BITS'(1);
    end

    pgm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_a (
        .i_clk  (i_clk),
        .i_we   (r_state == FS_UPD),
        .i_waddr(r_c),
        .i_wdata(r_p),
        .i_raddr(c_eff),
        .o_rdata(mid)
    );

    pgm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_b (
        .i_clk  (i_clk),
        .i_we   (r_state == FS_UPD),
        .i_waddr(r_c),
        .i_wdata(mid),
        .i_raddr(c_eff),
        .o_rdata(top)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: if (accept) n_state = FS_UPD;
            FS_UPD:  n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    assign interior = (r_r >= ROW_BITS'(2)) && (r_c >= CW'(2));

    always_comb begin
        o_push     = (r_state == FS_UPD) && interior;
        o_item.ix  = $signed({1'b0, mid}) - $signed({1'b0, r_win[1][1]});
        o_item.iy  = $signed({1'b0, r_win[2][2]}) - $signed({1'b0, r_win[0][2]});
        o_item.cx  = POS_BITS'(r_c) - POS_BITS'(1);
        o_item.cy  = POS_BITS'(r_r) - POS_BITS'(1);
        o_item.eof = (CFG_BITS'(r_r) == h_cl - CFG_BITS'(1))
                  && (WW'(r_c) == w_cl - WW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == FS_UPD) begin
                if (c_next >= w_cl) begin
                    r_col <= '0;
                    r_row <= (r_next >= h_cl) ? '0 : ROW_BITS'(r_next);
                end else begin
                    r_col <= CW'(c_next);
                    r_row <= r_r;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c <= c_eff;
            r_r <= r_eff;
            r_p <= i_pixel;
        end
        if (r_state == FS_UPD) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= top;
            r_win[1][2] <= mid;
            r_win[2][2] <= r_p;
        end
    end
endmodule

// ===== src/pgm_back.sv =====
// Back end: squared magnitude and iterative CORDIC angle, output register.
// Depends on pgm_pkg.
module pgm_back import pgm_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  t_grad_item            i_item,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [MAG_BITS-1:0]   o_mag,
    output logic [OUT_ANGLE_BITS-1:0] o_angle,
    output logic [POS_BITS-1:0]   o_cx,
    output logic [POS_BITS-1:0]   o_cy,
    output logic                  o_eof
);
    typedef enum logic [2:0] {
        BS_IDLE = 3'b001,
        BS_RUN  = 3'b010,
        BS_DONE = 3'b100
    } t_back_state;

    t_back_state         r_state, n_state;
    t_grad_item          r_item;
    logic [MAG_BITS-1:0] r_mag;
    logic signed [31:0]  r_x, r_y;
    logic [31:0]         r_z;
    logic [4:0]          r_i;
    logic                r_ovalid;
    logic [MAG_BITS-1:0] r_omag;
    logic [OUT_ANGLE_BITS-1:0] r_oangle;
    logic [POS_BITS-1:0] r_ocx, r_ocy;
    logic                r_oeof;
    logic [8:0]          abs_x, abs_y;
    logic signed [31:0]  xs, ys;
    logic [31:0]         turn, rnd;
    logic [ANGLE_BITS-1:0] res;
    logic [OUT_ANGLE_BITS-1:0] angle;
    logic                load_out;

    assign o_pop    = (r_state == BS_IDLE) && !i_q_empty;
    assign load_out = (r_state == BS_DONE) && (!r_ovalid || i_ready);
    assign abs_x    = i_item.ix[8] ? 9'(-i_item.ix) : 9'(i_item.ix);
    assign abs_y    = i_item.iy[8] ? 9'(-i_item.iy) : 9'(i_item.iy);
    assign xs       = r_x >>> r_i;
    assign ys       = r_y >>> r_i;

    // Quadrant fold and rounding to the binary angle.
    always_comb begin
        if (r_item.ix[8] && !r_item.iy[8]) begin
            turn = 32'h8000_0000 - r_z;
        end else if (r_item.ix[8]) begin
            turn = r_z - 32'h8000_0000;
        end else if (r_item.iy[8]) begin
            turn = 32'd0 - r_z;
        end else begin
            turn = r_z;
        end
        rnd = turn + (32'd1 << (31 - ANGLE_BITS));
        res = rnd[31 -: ANGLE_BITS];
        if (r_item.ix == '0 && r_item.iy == '0) begin
            angle = '0;
        end else begin
            angle = OUT_ANGLE_BITS'(signed'(res));
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: if (o_pop) n_state = BS_RUN;
            BS_RUN:  if (r_i == 5'(CORDIC_STEPS - 1)) n_state = BS_DONE;
            BS_DONE: if (load_out) n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
            r_mag  <= MAG_BITS'(i_item.ix * i_item.ix + i_item.iy * i_item.iy);
            r_x    <= 32'(abs_x) << PRESCALE;
            r_y    <= 32'(abs_y) << PRESCALE;
            r_z    <= '0;
            r_i    <= '0;
        end else if (r_state == BS_RUN) begin
            if (r_y > 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_turn32(r_i);
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_turn32(r_i);
            end
            r_i <= r_i + 5'd1;
        end
        if (load_out) begin
            r_omag   <= r_mag;
            r_oangle <= angle;
            r_ocx    <= r_item.cx;
            r_ocy    <= r_item.cy;
            r_oeof   <= r_item.eof;
        end
    end

    assign o_valid = r_ovalid;
    assign o_mag   = r_omag;
    assign o_angle = r_oangle;
    assign o_cx    = r_ocx;
    assign o_cy    = r_ocy;
    assign o_eof   = r_oeof;
endmodule

// ===== src/pixel_gradient_mag_angle.sv =====
// Top level of the gradient magnitude / direction block.
// Depends on pgm_pkg, pgm_front, pgm_fifo, pgm_back.
//
// Usage:
//   Slave stream: one smoothed 8-bit pixel per transaction in raster order,
//   tuser = start of frame (resets position to column 0, row 0).
//   Master stream: one result per interior pixel (full 3x3 neighborhood);
//   tlast marks the result for the center (width-2, height-2).
//   Config channel: index 0 = line width, 1 = frame height, 12-bit data,
//   always ready; write only while the block is idle.
// Throughput: the front takes a new pixel only after the line store read and
//   update of the last one; the back holds one interior result at a time
//   (load, 30 CORDIC iterations, output load), so the CORDIC loop sets the
//   sustained rate once the 4-entry queue fills.
// Reset: synchronous, active low; position counters and handshakes cleared,
//   registers back to 640 x 480. Line stores are not cleared.
// Stall: the output register holds its transaction; the back waits, the
//   queue fills, and then the slave side drops tready.
module pixel_gradient_mag_angle import pgm_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,  // [7:0] pixel
    input  logic                    s_axis_tuser,  // [0] start_of_frame
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [16:0] magnitude, [32:17] angle, [43:33] center_x, [54:44] center_y,
    // [55] zero
    output logic [55:0]             m_axis_tdata,
    output logic                    m_axis_tlast,  // end_of_frame
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);
    logic [CFG_BITS-1:0] r_line_width, r_frame_height;
    logic                q_full, q_empty, push, pop;
    t_grad_item          push_item, pop_item;
    logic [MAG_BITS-1:0] mag;
    logic [OUT_ANGLE_BITS-1:0] angle;
    logic [POS_BITS-1:0] cx, cy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LINE_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pgm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_pixel       (s_axis_tdata),
        .i_sof         (s_axis_tuser),
        .i_line_width  (r_line_width),
        .i_frame_height(r_frame_height),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_item        (push_item)
    );

    pgm_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (push_item),
        .o_full (q_full),
        .i_pop  (pop),
        .o_item (pop_item),
        .o_empty(q_empty)
    );

    pgm_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(q_empty),
        .i_item   (pop_item),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_mag    (mag),
        .o_angle  (angle),
        .o_cx     (cx),
        .o_cy     (cy),
        .o_eof    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, cy, cx, angle, mag};
endmodule

// ===== src/pgm_checker.sv =====
// Port-level checker for pixel_gradient_mag_angle, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module pgm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    `ASSERT_CLK(a_idle_after_reset, i_clk, !i_rst_n |=> !m_axis_tvalid)
    `ASSERT_CLK_RST(a_hold_on_stall, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_CLK_RST(a_mag_range, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[16:0] <= 17'd130050)
    `ASSERT_CLK_RST(a_zero_angle, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[16:0] == 17'd0 |-> m_axis_tdata[32:17] == 16'd0)
    `ASSERT_CLK_RST(a_interior, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[43:33] != 11'd0 && m_axis_tdata[54:44] != 11'd0)
endmodule

bind pixel_gradient_mag_angle pgm_checker u_pgm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
